// ===== rtl/gap_buffer_line_editor_macros.svh =====
// Assertion macros shared by the gap buffer line editor RTL.
`ifndef GAP_BUFFER_LINE_EDITOR_MACROS_SVH
`define GAP_BUFFER_LINE_EDITOR_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst is high.
`define GBLE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gap buffer line editor: same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled while rst is high.
`define GBLE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gap buffer line editor: next-cycle check failed");

`endif

// ===== rtl/gble_pkg.sv =====
// Package with the sizes, codes and state type of the gap buffer line editor.
package gble_pkg;

  localparam int DEPTH     = 65536;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int MODE_W    = 3;
  localparam int CHAR_W    = 8;
  localparam int POS_W     = 16;
  localparam int STATUS_W  = 2;
  localparam int OUT_CNT_W = 17;

  typedef logic [MODE_W-1:0]    mode_t;
  typedef logic [CHAR_W-1:0]    char_t;
  typedef logic [POS_W-1:0]     pos_t;
  typedef logic [STATUS_W-1:0]  status_t;
  typedef logic [OUT_CNT_W-1:0] out_cnt_t;

  localparam mode_t MODE_INSERT    = 3'd0;
  localparam mode_t MODE_LEFT      = 3'd1;
  localparam mode_t MODE_BACKSPACE = 3'd2;
  localparam mode_t MODE_RIGHT     = 3'd3;
  localparam mode_t MODE_READ      = 3'd4;

  localparam status_t STATUS_DONE    = 2'd0;
  localparam status_t STATUS_IGNORED = 2'd1;
  localparam status_t STATUS_FULL    = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

endpackage

// ===== rtl/gble_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
module gble_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== rtl/gap_buffer_line_editor.sv =====
// Top level of the gap buffer line editor: control, counters and result register.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+--------------------------------------
//   in      | input     | in_valid / in_ready   | mode, character, position
//   out     | output    | out_valid / out_ready | status, read_char, cursor, text_length
//
// With the output drained, each beat on the input passes through two steps: the accept
// cycle issues the memory read, the execute cycle writes back and loads the result.
// Both steps share the single port of the text memory, so a new beat is accepted only in idle.
// Reset clears the two counters; the memory is not cleared.
// The execute cycle waits while the result register holds a beat not yet taken.
module gap_buffer_line_editor (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  gble_pkg::mode_t     mode,
  input  gble_pkg::char_t     character,
  input  gble_pkg::pos_t      position,
  output logic                out_valid,
  input  logic                out_ready,
  output gble_pkg::status_t   status,
  output gble_pkg::char_t     read_char,
  output gble_pkg::out_cnt_t  cursor,
  output gble_pkg::out_cnt_t  text_length
);

  import gble_pkg::*;

`include "gap_buffer_line_editor_macros.svh"

  // Width wide enough to compare a position with a count.
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int SUM_W = CMP_W + 1;

  state_t state, state_next;

  // Characters left and right of the cursor.
  logic [CNT_W-1:0] left_count, left_count_next;
  logic [CNT_W-1:0] right_count, right_count_next;

  // The command being executed, captured at the accept edge.
  mode_t cmd_mode;
  char_t cmd_char;
  logic  cmd_oor;

  logic accept;
  logic out_free;
  logic load_result;

  logic [CNT_W-1:0]  total;
  logic [CNT_W-1:0]  left_dec;
  logic [CNT_W-1:0]  right_top;
  logic [CNT_W-1:0]  right_slot;
  logic [CMP_W-1:0]  pos_ext;
  logic [CMP_W-1:0]  total_ext;
  logic [CMP_W-1:0]  left_ext;
  logic [SUM_W-1:0]  right_pos;
  logic              pos_oor;
  logic [ADDR_W-1:0] read_addr;

  status_t status_next;
  char_t   read_char_next;

  logic              mem_we;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_addr;
  char_t             mem_wdata;
  char_t             mem_rdata;

  gble_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (DEPTH)
  ) u_text_store (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Address arithmetic on the two stacks. The right stack's top sits at
  // DEPTH - right_count and the free slot below it at one less.
  assign total      = left_count + right_count;
  assign left_dec   = left_count - CNT_W'(1);
  assign right_top  = CNT_W'(DEPTH) - right_count;
  assign right_slot = right_top - CNT_W'(1);

  // A position left of the cursor reads the left stack directly; otherwise
  // it is an offset into the right stack from its top.
  assign pos_ext   = CMP_W'(position);
  assign total_ext = CMP_W'(total);
  assign left_ext  = CMP_W'(left_count);
  assign pos_oor   = (pos_ext >= total_ext);
  assign right_pos = SUM_W'(right_top) + SUM_W'(pos_ext) - SUM_W'(left_ext);
  assign read_addr = (pos_ext < left_ext) ? pos_ext[ADDR_W-1:0] : right_pos[ADDR_W-1:0];

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: memory port, counters and the result.
  always_comb begin
    in_ready         = 1'b0;
    load_result      = 1'b0;
    mem_we           = 1'b0;
    mem_re           = 1'b0;
    mem_addr         = left_count[ADDR_W-1:0];
    mem_wdata        = cmd_char;
    left_count_next  = left_count;
    right_count_next = right_count;
    status_next      = STATUS_DONE;
    read_char_next   = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (mode)
            MODE_LEFT: begin
              mem_re   = (left_count != '0);
              mem_addr = left_dec[ADDR_W-1:0];
            end
            MODE_RIGHT: begin
              mem_re   = (right_count != '0);
              mem_addr = right_top[ADDR_W-1:0];
            end
            MODE_READ: begin
              mem_re   = !pos_oor;
              mem_addr = read_addr;
            end
            default: begin
              mem_re = 1'b0;
            end
          endcase
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          load_result = 1'b1;
          unique case (cmd_mode)
            MODE_INSERT: begin
              if (total == CNT_W'(DEPTH)) begin
                status_next = STATUS_FULL;
              end else begin
                mem_we          = 1'b1;
                mem_addr        = left_count[ADDR_W-1:0];
                mem_wdata       = cmd_char;
                left_count_next = left_count + CNT_W'(1);
              end
            end
            MODE_LEFT: begin
              if (left_count == '0) begin
                status_next = STATUS_IGNORED;
              end else begin
                mem_we           = 1'b1;
                mem_addr         = right_slot[ADDR_W-1:0];
                mem_wdata        = mem_rdata;
                left_count_next  = left_dec;
                right_count_next = right_count + CNT_W'(1);
              end
            end
            MODE_BACKSPACE: begin
              if (left_count == '0) begin
                status_next = STATUS_IGNORED;
              end else begin
                left_count_next = left_dec;
              end
            end
            MODE_RIGHT: begin
              if (right_count == '0) begin
                status_next = STATUS_IGNORED;
              end else begin
                mem_we           = 1'b1;
                mem_addr         = left_count[ADDR_W-1:0];
                mem_wdata        = mem_rdata;
                left_count_next  = left_count + CNT_W'(1);
                right_count_next = right_count - CNT_W'(1);
              end
            end
            MODE_READ: begin
              if (cmd_oor) begin
                status_next = STATUS_IGNORED;
              end else begin
                read_char_next = mem_rdata;
              end
            end
            default: begin
              status_next = STATUS_IGNORED;
            end
          endcase
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      left_count  <= '0;
      right_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      left_count  <= left_count_next;
      right_count <= right_count_next;
      if (load_result) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Command and result payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_mode <= mode;
      cmd_char <= character;
      cmd_oor  <= pos_oor;
    end
    if (load_result) begin
      status      <= status_next;
      read_char   <= read_char_next;
      cursor      <= OUT_CNT_W'(left_count_next);
      text_length <= OUT_CNT_W'(left_count_next + right_count_next);
    end
  end

  // The counters move only when a result is loaded.
  `GBLE_ASSERT_NEXT(a_counts_hold, !load_result, $stable(left_count) && $stable(right_count))
  // A loaded result reports the counters as they stand afterwards.
  `GBLE_ASSERT_NEXT(a_result_counts, load_result,
    out_valid && cursor == OUT_CNT_W'(left_count)
    && text_length == OUT_CNT_W'(left_count + right_count))
  // The two stacks never overlap.
  `GBLE_ASSERT_NOW(a_no_overflow, 1'b1, (SUM_W'(left_count) + SUM_W'(right_count)) <= SUM_W'(DEPTH))
  // An accepted beat enters the execute state in the following cycle.
  `GBLE_ASSERT_NEXT(a_accept_exec, accept, state == ST_EXEC)
  // The single memory port is never asked to read and write at once.
  `GBLE_ASSERT_NOW(a_one_access, mem_we, !mem_re)

endmodule

// ===== tb/gble_checker.sv =====
// Checker for the gap buffer line editor: predicts each result beat and compares it.
module gble_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  gble_pkg::mode_t    mode,
  input  gble_pkg::char_t    character,
  input  gble_pkg::pos_t     position,
  input  logic               out_valid,
  input  logic               out_ready,
  input  gble_pkg::status_t  status,
  input  gble_pkg::char_t    read_char,
  input  gble_pkg::out_cnt_t cursor,
  input  gble_pkg::out_cnt_t text_length,
  output int                 mismatches,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import gble_pkg::*;

  typedef struct packed {
    status_t  status;
    char_t    rd;
    out_cnt_t cursor;
    out_cnt_t length;
  } edit_result_t;

  char_t        text_store [DEPTH];
  int           left_n;
  int           right_n;
  edit_result_t results_due [$];

  initial begin
    mismatches = 0;
    pending    = 0;
    left_n     = 0;
    right_n    = 0;
  end

  // Applies one command to the shadow buffer and returns the result it gives.
  function automatic edit_result_t apply_edit(mode_t m, char_t c, pos_t p);
    edit_result_t r;
    int           total;
    total    = left_n + right_n;
    r        = '0;
    r.status = STATUS_DONE;
    case (m)
      MODE_INSERT: begin
        if (total >= DEPTH) begin
          r.status = STATUS_FULL;
        end else begin
          text_store[left_n] = c;
          left_n++;
        end
      end
      MODE_LEFT: begin
        if (left_n == 0) begin
          r.status = STATUS_IGNORED;
        end else begin
          left_n--;
          right_n++;
          text_store[DEPTH - right_n] = text_store[left_n];
        end
      end
      MODE_BACKSPACE: begin
        if (left_n == 0) r.status = STATUS_IGNORED;
        else left_n--;
      end
      MODE_RIGHT: begin
        if (right_n == 0) begin
          r.status = STATUS_IGNORED;
        end else begin
          text_store[left_n] = text_store[DEPTH - right_n];
          left_n++;
          right_n--;
        end
      end
      MODE_READ: begin
        if (int'(p) >= total) r.status = STATUS_IGNORED;
        else if (int'(p) < left_n) r.rd = text_store[int'(p)];
        else r.rd = text_store[DEPTH - right_n + (int'(p) - left_n)];
      end
      default: r.status = STATUS_IGNORED;
    endcase
    r.cursor = out_cnt_t'(left_n);
    r.length = out_cnt_t'(left_n + right_n);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t ns: mismatch on %s, got %0h, want %0h", $time, what, got, want);
    mismatches++;
  endtask

  // The result beat is handled before the command beat of the same edge, as it
  // can only belong to an older command.
  always @(posedge clk) begin : watch_beats
    edit_result_t want;
    if (rst) begin
      left_n  = 0;
      right_n = 0;
      results_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          report_mismatch("result beat with none due, status", 32'(status), '0);
        end else begin
          want = results_due.pop_front();
          if (status !== want.status)
            report_mismatch("status", 32'(status), 32'(want.status));
          if (read_char !== want.rd)
            report_mismatch("read_char", 32'(read_char), 32'(want.rd));
          if (cursor !== want.cursor)
            report_mismatch("cursor", 32'(cursor), 32'(want.cursor));
          if (text_length !== want.length)
            report_mismatch("text_length", 32'(text_length), 32'(want.length));
        end
      end
      if (in_valid && in_ready)
        results_due.push_back(apply_edit(mode, character, position));
    end
    pending = results_due.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the gap buffer line editor: clock, reset, stimulus and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import gble_pkg::*;

  localparam realtime HALF_PERIOD  = 6.0;
  localparam int      RESET_CYCLES = 3;
  localparam int      RANDOM_ITEMS = 1500;
  // Length of the single long receiver hold-off, in cycles.
  localparam int      HOLD_CYCLES  = 300;
  // Cycles without any beat on either channel before the run is called hung.
  localparam int      IDLE_LIMIT   = 2000;
  // Settling time after the last result.
  localparam int      DRAIN_CYCLES = 10;
  localparam int      HOLD_AT      = 400;
  localparam int      PAUSE_AT     = 900;
  localparam int      TAIL_ITEMS   = 20;

  // Ways in which the receiver paces its ready signal.
  typedef enum int {
    RX_ALWAYS,
    RX_HALF,
    RX_SPARSE,
    RX_PULSED
  } rx_style_e;

  logic     clk       = 1'b0;
  logic     rst       = 1'b1;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  mode_t    mode      = MODE_INSERT;
  char_t    character = '0;
  pos_t     position  = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  status_t  status;
  char_t    read_char;
  out_cnt_t cursor;
  out_cnt_t text_length;

  int mismatches;
  int pending;

  // Sender and receiver controls. With tx_steady or rx_steady set, that side
  // never idles; hold_request is raised by the stimulus and cleared by the
  // receiver once its hold-off has run out.
  bit tx_steady    = 1'b0;
  bit rx_steady    = 1'b0;
  bit hold_request = 1'b0;
  int burst_left   = 0;

  // Cursor and length as the stimulus expects them; used only to shape the
  // commands, never to check anything.
  int left_n  = 0;
  int right_n = 0;

  always #(HALF_PERIOD) clk = ~clk;

  gap_buffer_line_editor u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .mode        (mode),
    .character   (character),
    .position    (position),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .read_char   (read_char),
    .cursor      (cursor),
    .text_length (text_length)
  );

  gble_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .mode        (mode),
    .character   (character),
    .position    (position),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .read_char   (read_char),
    .cursor      (cursor),
    .text_length (text_length),
    .mismatches  (mismatches),
    .pending     (pending)
  );

  // Offers one command beat and returns at the falling edge after it was
  // taken. It is always entered at a falling edge. When a burst has run out
  // the valid is lowered for a random gap first, so that the gaps land on
  // both the accept and the execute cycle of the block's commands.
  task automatic edit(mode_t m, char_t c, pos_t p);
    if (!tx_steady && burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      // Now and then a long burst, so that stretches without idling occur.
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    case (m)
      MODE_INSERT:    if (left_n + right_n < DEPTH) left_n++;
      MODE_LEFT:      if (left_n > 0) begin left_n--; right_n++; end
      MODE_BACKSPACE: if (left_n > 0) left_n--;
      MODE_RIGHT:     if (right_n > 0) begin right_n--; left_n++; end
      default:        ;
    endcase
    in_valid  <= 1'b1;
    mode      <= m;
    character <= c;
    position  <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stops offering commands and waits until every result has come back. Every
  // command gives a result, so with nothing due the block is idle.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // Inserts dominate slightly so that the text grows over the run, while the
  // moves and deletes keep the cursor wandering through it.
  function automatic mode_t pick_mode();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 36) return MODE_INSERT;
    if (roll < 51) return MODE_LEFT;
    if (roll < 61) return MODE_BACKSPACE;
    if (roll < 76) return MODE_RIGHT;
    if (roll < 95) return MODE_READ;
    return mode_t'($urandom_range(int'(MODE_READ) + 1, (1 << MODE_W) - 1));
  endfunction

  // Most reads land inside the text; some sit on its last character or just
  // past it, and the rest are fully random so that every position bit toggles.
  function automatic pos_t pick_position();
    int total;
    int roll;
    total = left_n + right_n;
    roll  = $urandom_range(0, 9);
    if (total > 0 && roll < 6) return pos_t'($urandom_range(0, total - 1));
    if (roll == 6) return pos_t'(total - 1);
    if (roll == 7) return pos_t'(total);
    return pos_t'($urandom());
  endfunction

  function automatic char_t any_char();
    return char_t'($urandom_range(0, 255));
  endfunction

  // The receiver changes its pacing every so often. A hold-off request takes
  // precedence over everything else and keeps ready low for a long, counted
  // stretch, so that the result register fills and the input stalls behind it.
  initial begin : receiver
    rx_style_e rx_style;
    int        span;
    rx_style = RX_ALWAYS;
    span     = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end else if (rx_steady) begin
        out_ready <= 1'b1;
      end else begin
        if (span == 0) begin
          rx_style = rx_style_e'($urandom_range(int'(RX_ALWAYS), int'(RX_PULSED)));
          span     = $urandom_range(16, 128);
        end
        span--;
        case (rx_style)
          RX_ALWAYS: out_ready <= 1'b1;
          RX_HALF:   out_ready <= ($urandom_range(0, 1) == 1);
          RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
          default:   out_ready <= ((span % 8) < 3);
        endcase
      end
    end
  end

  // The watchdog ends the run if no beat moves on either channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    int    sent;
    int    run;
    int    roll;
    int    k;
    bit    hold_done;
    bit    paused;
    mode_t m;
    hold_done = 1'b0;
    paused    = 1'b0;

    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    // Directed opening. On the empty buffer every move, delete and read is
    // refused, as are the unused mode codes.
    edit(MODE_READ, 8'h00, 16'h0000);
    edit(MODE_READ, 8'hFF, 16'hFFFF);
    edit(MODE_LEFT, any_char(), pos_t'($urandom()));
    edit(MODE_BACKSPACE, any_char(), pos_t'($urandom()));
    edit(MODE_RIGHT, any_char(), pos_t'($urandom()));
    for (k = int'(MODE_READ) + 1; k < (1 << MODE_W); k++)
      edit(mode_t'(k), any_char(), pos_t'($urandom()));
    // Extreme and alternating characters, then reads across the whole text
    // and one just past its end.
    edit(MODE_INSERT, 8'h00, 16'hFFFF);
    edit(MODE_INSERT, 8'hFF, 16'h0000);
    edit(MODE_INSERT, 8'hA5, 16'h5A5A);
    edit(MODE_INSERT, 8'h5A, 16'hA5A5);
    for (k = 0; k <= 4; k++) edit(MODE_READ, 8'h00, pos_t'(k));
    // With the cursor moved back, reads must reach into the right-hand stack.
    edit(MODE_LEFT, 8'h00, 16'h0000);
    edit(MODE_LEFT, 8'h00, 16'h0000);
    edit(MODE_READ, 8'h00, 16'd1);
    edit(MODE_READ, 8'h00, 16'd3);
    edit(MODE_INSERT, 8'h81, 16'h0000);
    edit(MODE_READ, 8'h00, 16'd2);
    edit(MODE_BACKSPACE, 8'h00, 16'h0000);
    edit(MODE_RIGHT, 8'h00, 16'h0000);
    edit(MODE_RIGHT, 8'h00, 16'h0000);
    edit(MODE_RIGHT, 8'h00, 16'h0000);
    drain_results();

    // Random editing. Runs of cursor moves drive the cursor onto either edge;
    // part way through the receiver holds off while commands keep coming, and
    // later the sender waits for every result before carrying on.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent >= HOLD_AT && !hold_done) begin
        hold_request = 1'b1;
        hold_done    = 1'b1;
      end
      if (sent >= PAUSE_AT && !paused) begin
        drain_results();
        paused = 1'b1;
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        run = $urandom_range(1, 40);
        repeat (run) edit(MODE_LEFT, any_char(), pos_t'($urandom()));
        sent += run;
      end else if (roll < 6) begin
        run = $urandom_range(1, 40);
        repeat (run) edit(MODE_RIGHT, any_char(), pos_t'($urandom()));
        sent += run;
      end else begin
        m = pick_mode();
        edit(m, any_char(), (m == MODE_READ) ? pick_position() : pos_t'($urandom()));
        sent++;
      end
    end

    // Commands back to back with neither side idling: reads at the extreme
    // positions, moves across the cursor and inserts and deletes beside it.
    drain_results();
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    edit(MODE_INSERT, 8'hFF, 16'h0000);
    edit(MODE_READ, 8'h00, 16'hFFFF);
    edit(MODE_READ, 8'h00, 16'h0000);
    edit(MODE_LEFT, 8'h00, 16'h0000);
    edit(MODE_LEFT, 8'h00, 16'h0000);
    edit(MODE_INSERT, 8'h00, 16'h0000);
    edit(MODE_BACKSPACE, 8'h00, 16'h0000);
    edit(MODE_INSERT, 8'hC3, 16'h0000);
    edit(MODE_READ, 8'h00, 16'hFFFF);
    edit(MODE_READ, 8'h00, 16'hFFFE);
    edit(MODE_RIGHT, 8'h00, 16'h0000);
    edit(MODE_RIGHT, 8'h00, 16'h0000);
    edit(MODE_RIGHT, 8'h00, 16'h0000);
    edit(MODE_READ, 8'h00, 16'hFFFF);

    // A short random tail with idling on both sides again.
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    repeat (TAIL_ITEMS) begin
      m = pick_mode();
      edit(m, any_char(), (m == MODE_READ) ? pick_position() : pos_t'($urandom()));
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
